/* hdl/imu_sample_conditioner_unit_assert.svh */
// Assertion macros for the IMU sample conditioner.
`ifndef IMU_SAMPLE_CONDITIONER_UNIT_ASSERT_SVH
`define IMU_SAMPLE_CONDITIONER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define ISC_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define ISC_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`else
`define ISC_ASSERT(lbl, cond, msg)
`define ISC_ASSERT_IMP(lbl, pre, post, msg)
`endif
`endif

/* hdl/isc_pkg.sv */
package isc_pkg;

  localparam int AXES        = 6;
  localparam int SAT_LIMIT   = 32760;
  localparam int RAW_W       = 16;
  localparam int WORDS       = 7;
  localparam int IN_DATA_W   = 112;
  localparam int IN_USER_W   = 2;
  localparam int OUT_DATA_W  = 216;
  localparam int OUT_USER_W  = 3;
  localparam int ADDR_W      = 5;
  localparam int GAIN_W      = 24;
  localparam int BIAS_W      = 25;
  localparam int SUM_W       = 33;
  localparam int O_W         = 17;
  localparam int V_W         = 26;
  localparam int PROD_W      = 51;
  localparam int RND_SHIFT   = 16;
  localparam int TEMP_MUL    = 50251;
  localparam int TEMP_OFFSET = 5376;
  localparam int CAL_MIN     = 100;
  localparam int CNT_W       = 16;
  localparam int DIV_W       = 42;
  localparam int DEN_W       = 16;
  localparam int DIV_CNT_W   = $clog2(DIV_W + 1);

  typedef enum logic [2:0] {
    REG_ACCEL_GAIN = 3'd0,
    REG_GYRO_GAIN  = 3'd1,
    REG_ORIENT     = 3'd2,
    REG_CAL_TOTAL  = 3'd3,
    REG_ONE_G      = 3'd4,
    REG_ERR_LIMIT  = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BUS_FAIL  = 2'd1,
    ST_FLOATING  = 2'd2,
    ST_SATURATED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CAL_NONE = 2'd0,
    CAL_PASS = 2'd1,
    CAL_FAIL = 2'd2
  } cal_result_t;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SUB    = 8'b0000_0010,
    S_MUL    = 8'b0000_0100,
    S_RND    = 8'b0000_1000,
    S_UPD    = 8'b0001_0000,
    S_DSTART = 8'b0010_0000,
    S_DWAIT  = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic [GAIN_W-1:0] accel_gain;
    logic [GAIN_W-1:0] gyro_gain;
    logic [3:0]        orientation;
    logic [CNT_W-1:0]  cal_sample_total;
    logic [14:0]       one_g_counts;
    logic [7:0]        error_limit;
  } cfg_t;

  function automatic logic axis_saturated(input logic signed [RAW_W-1:0] a);
    return (int'(a) >= SAT_LIMIT) || (int'(a) <= -SAT_LIMIT);
  endfunction

endpackage

/* hdl/imu_sample_conditioner_unit.sv */
// IMU sample conditioner. Each input word is one raw frame of three accelerometer axes, die
// temperature and three gyro axes; each gives exactly one output word with the Q16.16 axes,
// Q8.8 temperature and status. One shared 26 x 25 bit multiplier scales the six axes and the
// temperature in turn, each through the subtract, multiply and round states; a rejected frame
// skips them. The last sample of a passing calibration run also drives a bit-serial divider
// once per axis for the mean offsets before that word is output. The input is ready again as
// soon as the result is in the output register, even while that word still waits to be taken.
module imu_sample_conditioner_unit
  import isc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // accel x, accel y, accel z, temperature, gyro x, gyro y, gyro z
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // action, bus_ok
  input  logic [IN_USER_W-1:0]  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // accel x/y/z, rate x/y/z, temperature_c, healthy, calibrated, cal_result, zero pad
  output logic [OUT_DATA_W-1:0] m_tdata,
  // sample_valid, status
  output logic [OUT_USER_W-1:0] m_tuser,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t cfg;
  state_t state;
  logic [2:0] k;
  logic [2:0] dk;

  logic signed [O_W-1:0]    o [AXES];
  logic signed [RAW_W-1:0]  temp_word;
  logic                     item_cal;
  logic                     item_valid;
  status_t                  item_status;
  cal_result_t              item_calres;
  logic signed [V_W-1:0]    v_reg;
  logic [GAIN_W-1:0]        gain_reg;
  logic signed [PROD_W-1:0] prod;
  logic signed [31:0]       res [AXES];
  logic signed [RAW_W-1:0]  temp_res;

  logic signed [BIAS_W-1:0] bias [AXES];
  logic                     bias_active;
  logic signed [SUM_W-1:0]  sums [AXES];
  logic [CNT_W-1:0]         cal_taken;
  logic [CNT_W-1:0]         cal_good;
  logic [7:0]               error_run;
  logic                     health;

  logic                     accept;
  logic signed [RAW_W-1:0]  w [WORDS];
  logic signed [RAW_W-1:0]  a [AXES];
  logic signed [O_W-1:0]    ob [AXES];
  logic                     floating;
  logic                     sat_in;
  status_t                  status_in;

  logic signed [BIAS_W-1:0] bias_sel;
  logic signed [V_W-1:0]    v_next;
  logic [GAIN_W-1:0]        gain_next;

  logic                     prod_neg;
  logic [PROD_W-1:0]        prod_mag;
  logic [PROD_W:0]          rnd_sum;
  logic signed [36:0]       sres;
  logic signed [36:0]       tsum;
  logic signed [31:0]       res_sat;
  logic signed [RAW_W-1:0]  temp_sat;

  logic [CNT_W-1:0]         total_eff;
  logic [CNT_W-1:0]         taken_n;
  logic [CNT_W-1:0]         good_n;
  logic [20:0]              pass_lhs;
  logic [20:0]              pass_rhs;
  logic                     run_end;
  logic                     run_pass;
  logic [7:0]               err_n;

  logic                     sum_neg;
  logic [SUM_W-1:0]         sum_mag;
  logic [DIV_W-1:0]         dividend;
  logic                     div_start;
  logic                     div_done;
  logic [DIV_W-1:0]         quotient;
  logic signed [BIAS_W-1:0] q_signed;
  logic signed [BIAS_W-1:0] bias_new;
  logic                     out_free;

  isc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  isc_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (cal_good),
    .done     (div_done),
    .quotient (quotient)
  );

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    for (int i = 0; i < WORDS; i++) begin
      w[i] = s_tdata[RAW_W*i +: RAW_W];
    end
    a[0] = w[0];
    a[1] = w[1];
    a[2] = w[2];
    a[3] = w[4];
    a[4] = w[5];
    a[5] = w[6];
    floating = (s_tdata == '0) || (&s_tdata);
    sat_in = 1'b0;
    for (int i = 0; i < AXES; i++) begin
      sat_in = sat_in | axis_saturated(a[i]);
    end
    if (!s_tuser[1]) begin
      status_in = ST_BUS_FAIL;
    end else if (floating) begin
      status_in = ST_FLOATING;
    end else if (sat_in) begin
      status_in = ST_SATURATED;
    end else begin
      status_in = ST_OK;
    end
    for (int i = 0; i < AXES; i++) begin
      ob[i] = O_W'(a[i]);
    end
    if (cfg.orientation[0]) begin
      ob[0] = O_W'(a[1]);
      ob[1] = O_W'(a[0]);
      ob[3] = O_W'(a[4]);
      ob[4] = O_W'(a[3]);
    end
    if (cfg.orientation[1]) begin
      ob[0] = -ob[0];
      ob[3] = -ob[3];
    end
    if (cfg.orientation[2]) begin
      ob[1] = -ob[1];
      ob[4] = -ob[4];
    end
    if (cfg.orientation[3]) begin
      ob[2] = -ob[2];
      ob[5] = -ob[5];
    end
  end

  always_comb begin
    bias_sel  = '0;
    v_next    = V_W'(temp_word);
    gain_next = GAIN_W'(TEMP_MUL);
    if (k < 3'(AXES)) begin
      bias_sel  = (bias_active && !item_cal) ? bias[k] : '0;
      v_next    = V_W'(signed'({o[k], 8'b0})) - V_W'(bias_sel);
      gain_next = (k < 3'd3) ? cfg.accel_gain : cfg.gyro_gain;
    end
  end

  always_comb begin
    prod_neg = prod[PROD_W-1];
    prod_mag = prod_neg ? PROD_W'(-prod) : PROD_W'(prod);
    rnd_sum  = {1'b0, prod_mag} + (PROD_W+1)'(32768);
    sres     = signed'({1'b0, rnd_sum[PROD_W:RND_SHIFT]});
    if (prod_neg) begin
      sres = -sres;
    end
    if (sres > 37'sd2147483647) begin
      res_sat = 32'sh7FFFFFFF;
    end else if (sres < -37'sd2147483648) begin
      res_sat = 32'sh80000000;
    end else begin
      res_sat = sres[31:0];
    end
    tsum = sres + 37'(TEMP_OFFSET);
    if (tsum > 37'sd32767) begin
      temp_sat = 16'sh7FFF;
    end else if (tsum < -37'sd32768) begin
      temp_sat = 16'sh8000;
    end else begin
      temp_sat = tsum[RAW_W-1:0];
    end
  end

  always_comb begin
    total_eff = (cfg.cal_sample_total < CNT_W'(CAL_MIN)) ? CNT_W'(CAL_MIN)
                                                          : cfg.cal_sample_total;
    taken_n   = (cal_taken == '1) ? cal_taken : cal_taken + 1'b1;
    good_n    = (item_valid && cal_good != '1) ? cal_good + 1'b1 : cal_good;
    pass_lhs  = 21'({good_n, 3'b0}) + 21'({good_n, 1'b0}) + 21'd10;
    pass_rhs  = 21'({total_eff, 3'b0}) + 21'(total_eff);
    run_end   = taken_n >= total_eff;
    run_pass  = (pass_lhs > pass_rhs) && (good_n != '0);
    err_n     = (error_run == 8'hFF) ? error_run : error_run + 8'd1;
  end

  always_comb begin
    sum_neg   = sums[dk][SUM_W-1];
    sum_mag   = sum_neg ? SUM_W'(-sums[dk]) : SUM_W'(sums[dk]);
    dividend  = DIV_W'({sum_mag, 8'b0}) + DIV_W'(cal_good[CNT_W-1:1]);
    div_start = (state == S_DSTART);
    q_signed  = sum_neg ? -BIAS_W'(quotient) : BIAS_W'(quotient);
    bias_new  = q_signed;
    if (dk == 3'd2) begin
      bias_new = q_signed - BIAS_W'({cfg.one_g_counts, 8'b0});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      k           <= '0;
      dk          <= '0;
      m_tvalid    <= 1'b0;
      bias_active <= 1'b0;
      cal_taken   <= '0;
      cal_good    <= '0;
      error_run   <= '0;
      health      <= 1'b1;
      for (int i = 0; i < AXES; i++) begin
        bias[i] <= '0;
        sums[i] <= '0;
      end
    end else begin
      if (state == S_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            k     <= '0;
            state <= (status_in == ST_OK) ? S_SUB : S_UPD;
          end
        end
        S_SUB: state <= S_MUL;
        S_MUL: state <= S_RND;
        S_RND: begin
          k     <= k + 3'd1;
          state <= (k == 3'(AXES)) ? S_UPD : S_SUB;
        end
        S_UPD: begin
          state <= (item_cal && run_end && run_pass) ? S_DSTART : S_OUT;
          if (item_valid) begin
            error_run <= '0;
            health    <= 1'b1;
          end else begin
            error_run <= err_n;
            if (item_status != ST_SATURATED && err_n > cfg.error_limit) begin
              health <= 1'b0;
            end
          end
          if (item_cal) begin
            if (run_end && !run_pass) begin
              cal_taken <= '0;
              cal_good  <= '0;
              for (int i = 0; i < AXES; i++) begin
                sums[i] <= '0;
              end
            end else begin
              cal_taken <= taken_n;
              cal_good  <= good_n;
              if (item_valid) begin
                for (int i = 0; i < AXES; i++) begin
                  sums[i] <= sums[i] + SUM_W'(o[i]);
                end
              end
            end
            if (run_end && run_pass) begin
              dk <= '0;
            end
          end
        end
        S_DSTART: state <= S_DWAIT;
        S_DWAIT: begin
          if (div_done) begin
            bias[dk] <= bias_new;
            if (dk == 3'(AXES - 1)) begin
              bias_active <= 1'b1;
              cal_taken   <= '0;
              cal_good    <= '0;
              for (int i = 0; i < AXES; i++) begin
                sums[i] <= '0;
              end
              state <= S_OUT;
            end else begin
              dk    <= dk + 3'd1;
              state <= S_DSTART;
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          for (int i = 0; i < AXES; i++) begin
            o[i]   <= ob[i];
            res[i] <= '0;
          end
          temp_word   <= w[3];
          temp_res    <= '0;
          item_cal    <= s_tuser[0];
          item_valid  <= (status_in == ST_OK);
          item_status <= status_in;
          item_calres <= CAL_NONE;
        end
      end
      S_SUB: begin
        v_reg    <= v_next;
        gain_reg <= gain_next;
      end
      S_MUL: prod <= v_reg * signed'({1'b0, gain_reg});
      S_RND: begin
        if (k == 3'(AXES)) begin
          temp_res <= temp_sat;
        end else begin
          res[k] <= res_sat;
        end
      end
      S_UPD: begin
        if (item_cal && run_end) begin
          item_calres <= run_pass ? CAL_PASS : CAL_FAIL;
        end
      end
      S_OUT: begin
        if (out_free) begin
          m_tdata <= {4'b0, item_calres, bias_active, health, temp_res,
                      res[5], res[4], res[3], res[2], res[1], res[0]};
          m_tuser <= {item_status, item_valid};
        end
      end
      default: ;
    endcase
  end

`include "imu_sample_conditioner_unit_assert.svh"

  `ISC_ASSERT(a_health_err, health || (error_run != 8'd0), "health low with no error run")
  `ISC_ASSERT(a_cal_counts, cal_good <= cal_taken, "good calibration count above taken")
  `ISC_ASSERT_IMP(a_rej_zero, m_tvalid && !m_tuser[0], m_tdata[207:0] == '0, "rejected data")
  `ISC_ASSERT_IMP(a_status_ok, m_tvalid, (m_tuser[2:1] == ST_OK) == m_tuser[0], "status mismatch")

endmodule

/* hdl/isc_regs.sv */
module isc_regs
  import isc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.accel_gain       <= GAIN_W'(2048);
      cfg.gyro_gain        <= GAIN_W'(511500);
      cfg.orientation      <= 4'd0;
      cfg.cal_sample_total <= CNT_W'(1000);
      cfg.one_g_counts     <= 15'd8192;
      cfg.error_limit      <= 8'd5;
    end else if (wr) begin
      case (idx)
        REG_ACCEL_GAIN: cfg.accel_gain       <= pwdata[GAIN_W-1:0];
        REG_GYRO_GAIN:  cfg.gyro_gain        <= pwdata[GAIN_W-1:0];
        REG_ORIENT:     cfg.orientation      <= pwdata[3:0];
        REG_CAL_TOTAL:  cfg.cal_sample_total <= pwdata[CNT_W-1:0];
        REG_ONE_G:      cfg.one_g_counts     <= pwdata[14:0];
        REG_ERR_LIMIT:  cfg.error_limit      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ACCEL_GAIN: prdata = 32'(cfg.accel_gain);
      REG_GYRO_GAIN:  prdata = 32'(cfg.gyro_gain);
      REG_ORIENT:     prdata = 32'(cfg.orientation);
      REG_CAL_TOTAL:  prdata = 32'(cfg.cal_sample_total);
      REG_ONE_G:      prdata = 32'(cfg.one_g_counts);
      REG_ERR_LIMIT:  prdata = 32'(cfg.error_limit);
      default:        prdata = 32'd0;
    endcase
  end

endmodule

/* hdl/isc_divider.sv */
module isc_divider
  import isc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  logic [DIV_CNT_W-1:0] cnt;
  logic [DEN_W-1:0]     rem;
  logic [DEN_W-1:0]     den;
  logic [DEN_W:0]       trial;
  logic                 fits;

  assign trial = {rem, quotient[DIV_W-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= !start && (cnt == DIV_CNT_W'(1));
      if (start) begin
        cnt <= DIV_CNT_W'(DIV_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      den      <= divisor;
    end else if (cnt != '0) begin
      quotient <= {quotient[DIV_W-2:0], fits};
      rem      <= fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
    end
  end

endmodule
